// ===== sv/sli_pkg.sv =====
// Shared types and constants for the sorted list insert/remove block.
package sli_pkg;

  // Width of one stored value and of the value fields.
  localparam int unsigned ValueWidth = 32;

  // Width of the entry count field on the result channel.
  localparam int unsigned CountFieldWidth = 5;

  // Default number of table entries.
  localparam int unsigned CapacityDefault = 16;

  // Operation codes carried on the request channel.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_e;

  // Status codes returned with every result.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Per-cycle command broadcast from the controller to every cell.
  typedef struct packed {
    logic                         insert_en;
    logic                         remove_en;
    logic signed [ValueWidth-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== sv/sli_if.sv =====
// Request and result channel interfaces for the sorted list block.
interface sli_op_if;
  import sli_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [ValueWidth-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface sli_res_if;
  import sli_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [CountFieldWidth-1:0]   entry_count;
  logic signed [ValueWidth-1:0] smallest;
  logic signed [ValueWidth-1:0] largest;

  modport source (output valid, output status, output entry_count, output smallest,
                  output largest, input ready);
  modport sink   (input valid, input status, input entry_count, input smallest,
                  input largest, output ready);
endinterface

// ===== sv/sli_cell.sv =====
// One table cell: holds a single entry and shifts with its neighbors.
module sli_cell (
  input  logic                                 clk_i,
  input  logic                                 occupied_i,
  input  sli_pkg::cell_ctrl_t                  ctrl_i,
  input  logic                                 left_ge_i,
  input  logic signed [sli_pkg::ValueWidth-1:0] left_value_i,
  input  logic signed [sli_pkg::ValueWidth-1:0] right_value_i,
  output logic                                 ge_o,
  output logic                                 eq_o,
  output logic signed [sli_pkg::ValueWidth-1:0] value_o
);
  import sli_pkg::*;

  logic signed [ValueWidth-1:0] entry_q;
  logic signed [ValueWidth-1:0] entry_d;
  logic                         entry_we;

  // Compare the stored entry against the broadcast operand.
  assign ge_o    = occupied_i && !(entry_q < ctrl_i.value);
  assign eq_o    = occupied_i && (entry_q == ctrl_i.value);
  assign value_o = entry_q;

  // An insert shifts the upper part right and drops the operand into the gap;
  // a remove shifts everything from the match onward one place left.
  always_comb begin
    entry_we = 1'b0;
    entry_d  = entry_q;
    if (ctrl_i.insert_en) begin
      if (left_ge_i) begin
        entry_we = 1'b1;
        entry_d  = left_value_i;
      end else if (ge_o || !occupied_i) begin
        entry_we = 1'b1;
        entry_d  = ctrl_i.value;
      end
    end else if (ctrl_i.remove_en && ge_o) begin
      entry_we = 1'b1;
      entry_d  = right_value_i;
    end
  end

  // Entry storage; its contents only matter below the fill count.
  always_ff @(posedge clk_i) begin
    if (entry_we) begin
      entry_q <= entry_d;
    end
  end

endmodule

// ===== sv/sorted_list_insert_remove_core.sv =====
// Top level of the sorted list block: controller, cell row and result register.
//
// Keeps up to Capacity signed 32-bit values in ascending order in a row of
// cells. Each request on op_i carries an opcode (insert or remove) and a
// value. An insert lands in front of the first entry that is greater or
// equal; a remove deletes the first equal entry. Every request yields one
// transfer on res_o with a status (done, not found, empty, full), the entry
// count after the operation and the smallest and largest stored values
// (zero when the table is empty).
// All cells compare against the operand at once and shift together, so the
// table is updated at the accepting edge. The result leaves through a stage
// register and an output register: the stage register holds the status,
// and the output register takes it with the count and the smallest and
// largest values and raises res_o.valid. One request per cycle is sustained
// while res_o is not stalled.
// When res_o stalls, one further request is still taken and held in the
// stage register; after that op_i.ready drops until the output drains.
// Reset empties the table at once and clears the stage and output valid
// flags; no clearing pass is needed.
module sorted_list_insert_remove_core #(
  parameter int unsigned Capacity = sli_pkg::CapacityDefault
) (
  input logic        clk_i,
  input logic        rst_ni,
  sli_op_if.sink     op_i,
  sli_res_if.source  res_o
);
  import sli_pkg::*;

  localparam int unsigned CountWidth = $clog2(Capacity + 1);

  logic [CountWidth-1:0] count_q;
  logic [CountWidth-1:0] count_d;
  logic                  busy_q;
  logic                  busy_d;
  status_e               status_q;
  status_e               status_d;
  logic                  out_valid_q;
  logic                  out_valid_d;
  status_e               out_status_q;
  logic [CountWidth-1:0] out_count_q;
  logic signed [ValueWidth-1:0] out_smallest_q;
  logic signed [ValueWidth-1:0] out_largest_q;

  logic                  op_accept;
  logic                  out_move;
  logic                  table_full;
  logic                  table_empty;
  logic                  found;
  cell_ctrl_t            ctrl;

  logic [Capacity-1:0]          cell_ge;
  logic [Capacity-1:0]          cell_eq;
  logic [Capacity-1:0]          cell_occ;
  logic signed [ValueWidth-1:0] cell_value [Capacity];
  logic signed [ValueWidth-1:0] last_pick  [Capacity];
  logic signed [ValueWidth-1:0] largest_now;
  logic signed [ValueWidth-1:0] smallest_now;
  logic [CountWidth+CountFieldWidth-1:0] count_ext;

  // Handshake: the stage register frees up when it moves into the output.
  assign out_move  = busy_q && (!out_valid_q || res_o.ready);
  assign op_i.ready = !busy_q || out_move;
  assign op_accept = op_i.valid && op_i.ready;

  assign table_full  = (count_q == CountWidth'(Capacity));
  assign table_empty = (count_q == '0);
  assign found       = |cell_eq;

  // Command broadcast to the cell row for this cycle.
  always_comb begin
    ctrl.value     = op_i.value;
    ctrl.insert_en = op_accept && (opcode_e'(op_i.opcode) == OP_INSERT) && !table_full;
    ctrl.remove_en = op_accept && (opcode_e'(op_i.opcode) == OP_REMOVE) && found;
  end

  // Row of cells; each one sees its left and right neighbor.
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic                         left_ge;
    logic signed [ValueWidth-1:0] left_value;
    logic signed [ValueWidth-1:0] right_value;

    assign cell_occ[i] = (CountWidth'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_ge    = 1'b0;
      assign left_value = '0;
    end else begin : g_inner
      assign left_ge    = cell_ge[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_body
      assign right_value = cell_value[i+1];
    end

    sli_cell u_cell (
      .clk_i         (clk_i),
      .occupied_i    (cell_occ[i]),
      .ctrl_i        (ctrl),
      .left_ge_i     (left_ge),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .ge_o          (cell_ge[i]),
      .eq_o          (cell_eq[i]),
      .value_o       (cell_value[i])
    );

    // Only the last occupied cell contributes to the largest value.
    assign last_pick[i] = (count_q == CountWidth'(i + 1)) ? cell_value[i] : '0;
  end

  // Largest value: OR over the masked cell outputs.
  always_comb begin
    largest_now = '0;
    for (int unsigned i = 0; i < Capacity; i++) begin
      largest_now = largest_now | last_pick[i];
    end
  end

  assign smallest_now = table_empty ? '0 : cell_value[0];

  // Next fill count and status of the accepted request.
  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    if (ctrl.insert_en) begin
      count_d = count_q + CountWidth'(1);
    end else if (ctrl.remove_en) begin
      count_d = count_q - CountWidth'(1);
    end
    if (op_accept) begin
      if (opcode_e'(op_i.opcode) == OP_INSERT) begin
        status_d = table_full ? ST_FULL : ST_DONE;
      end else if (table_empty) begin
        status_d = ST_EMPTY;
      end else begin
        status_d = found ? ST_DONE : ST_NOT_FOUND;
      end
    end
  end

  // Stage and output valid flags.
  always_comb begin
    busy_d = busy_q;
    if (op_accept) begin
      busy_d = 1'b1;
    end else if (out_move) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_move) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: status stage and result register.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (out_move) begin
      out_status_q   <= status_q;
      out_count_q    <= count_q;
      out_smallest_q <= smallest_now;
      out_largest_q  <= largest_now;
    end
  end

  assign count_ext         = {{CountFieldWidth{1'b0}}, out_count_q};
  assign res_o.valid       = out_valid_q;
  assign res_o.status      = out_status_q;
  assign res_o.entry_count = count_ext[CountFieldWidth-1:0];
  assign res_o.smallest    = out_smallest_q;
  assign res_o.largest     = out_largest_q;

`ifndef SYNTHESIS
  // The fill count never runs past the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountWidth'(Capacity))
    else $error("fill count exceeds capacity");

  // An insert into a table with room grows the count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_accept && (opcode_e'(op_i.opcode) == OP_INSERT) && !table_full
    |=> count_q == $past(count_q) + CountWidth'(1))
    else $error("insert did not grow the table");

  // A refused operation leaves the count unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_accept && !ctrl.insert_en && !ctrl.remove_en |=> $stable(count_q))
    else $error("refused operation changed the table");

  // The table stays sorted: the reported smallest never exceeds the largest.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_count_q != '0) |-> out_smallest_q <= out_largest_q)
    else $error("table order broken");
`endif

endmodule
